@@ design/dcem_pkg.sv @@
// ----------------------------------------------------------------------------
// dcem_pkg
// Shared types, widths and codes of the dc energy meter accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package dcem_pkg;

    // field widths
    localparam int LEN_W    = 4;
    localparam int RAW_W    = 32;
    localparam int VRAW_W   = 16;
    localparam int TS_W     = 32;
    localparam int CUR_W    = 31;
    localparam int VOLT_W   = 26;
    localparam int DIV_W    = 32;
    localparam int FLOOR_W  = 16;
    localparam int ENERGY_W = 64;
    localparam int EVT_W    = 2;
    localparam int SCALE_W  = 10;

    // products: current x voltage, then times elapsed ms
    localparam int PW_W   = CUR_W + VOLT_W;
    localparam int PROD_W = PW_W + TS_W;

    // padded stream widths
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 128;

    // defaults
    localparam int SUM_BITS_DEF    = 128;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [DIV_W-1:0]   DIVISOR_RESET = 32'd3600000000;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET   = 16'd5;
    localparam logic [LEN_W-1:0]   MIN_LEN       = 4'd7;
    localparam logic [SCALE_W-1:0] VOLT_SCALE    = 10'd1000;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIVISOR = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR   = 1'b1;

    // session event codes
    typedef enum logic [EVT_W-1:0] {
        EVT_NONE  = 2'd0,
        EVT_START = 2'd1,
        EVT_STOP  = 2'd2
    } session_event_t;

    // decoded sample handed from front to back
    typedef struct packed {
        logic [CUR_W-1:0]  cur;
        logic [VOLT_W-1:0] volt;
        logic [TS_W-1:0]   ts;
    } item_t;

    // one result word
    typedef struct packed {
        logic                charging;
        session_event_t      event_code;
        logic [ENERGY_W-1:0] energy;
        logic [CUR_W-1:0]    cur;
        logic [VOLT_W-1:0]   volt;
    } result_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

@@ design/dcem_front.sv @@
// ----------------------------------------------------------------------------
// dcem_front
// Accepts meter frames, drops short ones, decodes current and voltage.
// ----------------------------------------------------------------------------
`default_nettype none

module dcem_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dcem_pkg::LEN_W-1:0]   frame_length,
    input  wire logic [dcem_pkg::RAW_W-1:0]   current_raw,
    input  wire logic [dcem_pkg::VRAW_W-1:0]  voltage_raw,
    input  wire logic [dcem_pkg::TS_W-1:0]    timestamp_ms,
    input  wire logic [dcem_pkg::FLOOR_W-1:0] current_floor,
    output dcem_pkg::item_t                   item,
    output logic                              item_valid,
    input  wire logic                         item_ready
);
    import dcem_pkg::*;

    logic             valid_reg;
    item_t            item_reg;
    item_t            item_next;
    logic [CUR_W-1:0] folded;

    // fold around mid-scale, then apply the floor
    always_comb
    begin
        folded         = current_raw[RAW_W-1] ? current_raw[CUR_W-1:0]
                                              : ~current_raw[CUR_W-1:0];
        item_next.cur  = (folded < CUR_W'(current_floor)) ? '0 : folded;
        item_next.volt = VOLT_W'(voltage_raw) * VOLT_W'(VOLT_SCALE);
        item_next.ts   = timestamp_ms;
    end

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag: short frames never enter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid && (frame_length >= MIN_LEN);
    end

    // decoded sample
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

`default_nettype wire

@@ design/dcem_fifo.sv @@
// ----------------------------------------------------------------------------
// dcem_fifo
// Short queue of decoded samples between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dcem_fifo
#(
    parameter int DEPTH = dcem_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_valid,
    output logic           wr_ready,
    input  wire dcem_pkg::item_t wr_item,
    output logic           rd_valid,
    input  wire logic      rd_ready,
    output dcem_pkg::item_t rd_item
);
    import dcem_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_item;
    end

endmodule

`default_nettype wire

@@ design/dcem_back.sv @@
// ----------------------------------------------------------------------------
// dcem_back
// Session tracking, energy multiply-accumulate and bit-serial division.
// ----------------------------------------------------------------------------
`default_nettype none

module dcem_back
#(
    parameter int SUM_BITS = dcem_pkg::SUM_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [dcem_pkg::DIV_W-1:0] energy_divisor,
    input  wire dcem_pkg::item_t            item,
    input  wire logic                       item_valid,
    output logic                            item_ready,
    output dcem_pkg::result_t               result,
    output logic                            result_valid,
    input  wire logic                       result_ready
);
    import dcem_pkg::*;

    localparam int CNT_W = $clog2(SUM_BITS);
    localparam int HI_W  = PW_W;

    back_state_t        state_reg;
    back_state_t        state_next;

    // architectural state
    logic [CUR_W-1:0]    last_cur_reg;
    logic [VOLT_W-1:0]   last_volt_reg;
    logic [TS_W-1:0]     last_ts_reg;
    logic                active_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic [ENERGY_W-1:0] energy_reg;

    // working registers
    session_event_t      event_reg;
    logic [CUR_W-1:0]    cur_hold_reg;
    logic [VOLT_W-1:0]   volt_hold_reg;
    logic [PW_W-1:0]     pw_reg;
    logic [TS_W-1:0]     delta_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SUM_BITS-1:0] dvd_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    logic                take;
    logic                load_out;
    logic                both_live;
    logic                do_start;
    logic                do_stop;
    logic                do_acc;
    logic [PW_W-1:0]     pw_next;
    logic [2*DIV_W-1:0]  lo_prod;
    logic [HI_W-1:0]     hi_prod;
    logic [SUM_BITS:0]   sum_ext;
    logic [SUM_BITS-1:0] sum_sat;
    logic [DIV_W:0]      rem_sh;
    logic [DIV_W:0]      rem_diff;
    logic                q_bit;
    logic [SUM_BITS-1:0] dvd_next;
    logic [ENERGY_W-1:0] quot_sat;

    // session decision from the previous sample
    assign both_live = (last_cur_reg != '0) && (last_volt_reg != '0);
    assign do_start  = both_live && !active_reg;
    assign do_stop   = !both_live && active_reg;
    assign do_acc    = both_live && active_reg;

    // datapath
    always_comb
    begin
        pw_next  = PW_W'(last_cur_reg) * PW_W'(last_volt_reg);
        lo_prod  = (2*DIV_W)'(pw_reg[DIV_W-1:0]) * (2*DIV_W)'(delta_reg);
        hi_prod  = HI_W'(pw_reg[PW_W-1:DIV_W]) * HI_W'(delta_reg);
        sum_ext  = {1'b0, sum_reg} + (SUM_BITS+1)'(prod_reg);
        sum_sat  = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
        rem_sh   = {rem_reg, dvd_reg[SUM_BITS-1]};
        rem_diff = rem_sh - {1'b0, energy_divisor};
        q_bit    = (rem_sh >= {1'b0, energy_divisor});
        dvd_next = {dvd_reg[SUM_BITS-2:0], q_bit};
        quot_sat = (dvd_next[SUM_BITS-1:ENERGY_W] != '0) ? '1 : dvd_next[ENERGY_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = do_acc ? ST_MUL_LO : ST_DONE;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ADD;
            ST_ADD:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        item_ready = (state_reg == ST_IDLE);
        load_out   = (state_reg == ST_DONE) && (!out_valid_reg || result_ready);
    end

    assign take         = item_ready && item_valid;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_cur_reg  <= '0;
            last_volt_reg <= '0;
            last_ts_reg   <= '0;
            active_reg    <= 1'b0;
            sum_reg       <= '0;
            energy_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                last_cur_reg  <= item.cur;
                last_volt_reg <= item.volt;
                last_ts_reg   <= item.ts;
                if (do_start)
                begin
                    active_reg <= 1'b1;
                    sum_reg    <= '0;
                    energy_reg <= '0;
                end
                else if (do_stop)
                    active_reg <= 1'b0;
            end
            if (state_reg == ST_ADD)
            begin
                sum_reg <= sum_sat;
                cnt_reg <= CNT_W'(SUM_BITS - 1);
            end
            if (state_reg == ST_DIV)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    energy_reg <= quot_sat;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_hold_reg  <= item.cur;
            volt_hold_reg <= item.volt;
            pw_reg        <= pw_next;
            delta_reg     <= item.ts - last_ts_reg;
            if (do_start)
                event_reg <= EVT_START;
            else if (do_stop)
                event_reg <= EVT_STOP;
            else
                event_reg <= EVT_NONE;
        end
        if (state_reg == ST_MUL_LO)
            prod_reg <= PROD_W'(lo_prod);
        if (state_reg == ST_MUL_HI)
            prod_reg <= prod_reg + (PROD_W'(hi_prod) << DIV_W);
        if (state_reg == ST_ADD)
        begin
            dvd_reg <= sum_sat;
            rem_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= q_bit ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        end
        if (load_out)
        begin
            out_reg.charging   <= active_reg;
            out_reg.event_code <= event_reg;
            out_reg.energy     <= energy_reg;
            out_reg.cur        <= cur_hold_reg;
            out_reg.volt       <= volt_hold_reg;
        end
    end

endmodule

`default_nettype wire

@@ design/dc_energy_meter_accumulator.sv @@
// ----------------------------------------------------------------------------
// dc_energy_meter_accumulator
// Meter frame decoder with charge session tracking and energy accumulation.
// ----------------------------------------------------------------------------
// s_axis carries one meter frame per word; frames with a length below seven
// are swallowed and give no result. m_axis carries one result word per used
// frame, session event code on tuser. cfg writes the energy divisor (index 0)
// and the current floor (index 1); its ready is always high.
// Path: a frame passes the front register and the queue into the back. When
// the frame starts, stops or leaves the session idle, the back passes it
// straight to the output register; when it accumulates, the back first forms
// 32-bit partial products, then makes the saturating add and runs the
// restoring divider, one bit a cycle. The back takes a new frame only after
// its last result has moved to the output register; a queue, two entries
// deep by default, sits ahead of it.
// Reset: clears session state, energy sum, reported energy, the front register
// and the queue; the divisor returns to 3600000000 and the floor to 5.
// Stalls: a word waits in the output register while m_axis_tready is low; the
// front and queue keep taking frames until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module dc_energy_meter_accumulator
#(
    parameter int SUM_BITS    = dcem_pkg::SUM_BITS_DEF,
    parameter int QUEUE_DEPTH = dcem_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // frame_length[3:0], current_raw[35:4], voltage_raw[51:36],
    // timestamp_ms[83:52], zero fill [87:84]
    input  wire logic [dcem_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // charging[0], energy[64:1], current_out[95:65], voltage_out[121:96],
    // zero fill [127:122]
    output logic [dcem_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // session_event[1:0]
    output logic [dcem_pkg::EVT_W-1:0]            m_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dcem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dcem_pkg::DIV_W-1:0]       cfg_data
);
    import dcem_pkg::*;

    localparam int FILL_W = OUT_DATA_W - (1 + ENERGY_W + CUR_W + VOLT_W);

    logic [DIV_W-1:0]   divisor_reg;
    logic [FLOOR_W-1:0] floor_reg;
    item_t              fr_item;
    logic               fr_valid;
    logic               fr_ready;
    item_t              q_item;
    logic               q_valid;
    logic               q_ready;
    result_t            res;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIVISOR_RESET;
            floor_reg   <= FLOOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DIVISOR: divisor_reg <= cfg_data;
                CFG_FLOOR:   floor_reg   <= cfg_data[FLOOR_W-1:0];
                default:     ;
            endcase
        end
    end

    // frame intake and decode
    dcem_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .frame_length  (s_axis_tdata[3:0]),
        .current_raw   (s_axis_tdata[35:4]),
        .voltage_raw   (s_axis_tdata[51:36]),
        .timestamp_ms  (s_axis_tdata[83:52]),
        .current_floor (floor_reg),
        .item          (fr_item),
        .item_valid    (fr_valid),
        .item_ready    (fr_ready)
    );

    // decoupling queue
    dcem_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_item  (fr_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // session and energy engine
    dcem_back #(.SUM_BITS(SUM_BITS)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .energy_divisor (divisor_reg),
        .item           (q_item),
        .item_valid     (q_valid),
        .item_ready     (q_ready),
        .result         (res),
        .result_valid   (m_axis_tvalid),
        .result_ready   (m_axis_tready)
    );

    // result word packing
    assign m_axis_tdata = {{FILL_W{1'b0}}, res.volt, res.cur, res.energy, res.charging};
    assign m_axis_tuser = res.event_code;

endmodule

`default_nettype wire
